FILE: hdl/ega_pkg.sv
// Package: shared types, constants and command codes of the elite archive.
`timescale 1ns / 1ps
`default_nettype none
package ega_pkg;
  localparam int BinsPerDim = 16;
  localparam int IdBits = 16;
  localparam int FitBits = 32;
  localparam int CountW = 13;
  localparam int NumDims = 3;

  typedef enum logic [2:0] {
    CMD_OFFER  = 3'd0,
    CMD_READ   = 3'd1,
    CMD_TOTAL  = 3'd2,
    CMD_UNIQUE = 3'd3,
    CMD_VALUE  = 3'd4,
    CMD_RANGE  = 3'd5,
    CMD_BAD6   = 3'd6,
    CMD_BAD7   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_SWEEP,
    ST_EMIT
  } back_state_t;
endpackage
`default_nettype wire

FILE: hdl/ega_if.sv
// Interface: valid/ready channel carrying one item of the given payload type.
`timescale 1ns / 1ps
`default_nettype none
interface ega_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/elite_grid_archive_core.sv
// Top level: three-dimensional elite archive with command and result channels.
//
// in_ch carries one command item (offer, read cell, or a count query);
// out_ch returns exactly one result item for each, in order.
// The front end classifies items (bad coordinate, dimension, command) and
// holds up to two in a queue; in_ch.ready drops only when that queue is full.
// The back end serves one item at a time from the queue:
//   offer / read cell: cell memory read, update, result register.
//   total count, count with value, bad item: result register only.
//   unique values, count in range: a sweep over all 16 bins, one bin counter
//   read per cycle from the per-dimension value counters.
// The single-port cell memory read-modify-write sets the offer rate.
// Reset clears the value counters and total at once, then clears the occupied
// bits of all 4096 cells, one cell a cycle, before the first item is served; cell
// fitness and id memories are not cleared and are used only when occupied.
// A stalled receiver holds the result; the queue keeps accepting until full.
`timescale 1ns / 1ps
`default_nettype none
module elite_grid_archive_core import ega_pkg::*; #(
  parameter int ID_BITS = IdBits,
  parameter int FIT_BITS = FitBits
) (
  input wire logic clk,
  input wire logic rst,
  ega_if.sink      in_ch,
  ega_if.source    out_ch
);
  localparam int QW = 1 + 3 + 12 + FIT_BITS + ID_BITS + 2 + 12;

  logic          q_valid, q_pop;
  logic [QW-1:0] q_data;

  ega_front #(.FW(FIT_BITS), .IW(ID_BITS), .QW(QW)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .cmd(in_ch.data.cmd), .coord_a(in_ch.data.coord_a), .coord_b(in_ch.data.coord_b),
    .coord_c(in_ch.data.coord_c), .fitness(in_ch.data.fitness),
    .genome_id(in_ch.data.genome_id), .dimension(in_ch.data.dimension),
    .query_value(in_ch.data.query_value), .range_low(in_ch.data.range_low),
    .range_high(in_ch.data.range_high),
    .q_valid, .q_pop, .q_data
  );

  ega_back #(.FW(FIT_BITS), .IW(ID_BITS), .QW(QW)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cell_occupied(out_ch.data.cell_occupied), .replaced(out_ch.data.replaced),
    .elite_fitness(out_ch.data.elite_fitness), .elite_id(out_ch.data.elite_id),
    .count(out_ch.data.count), .bad_request(out_ch.data.bad_request)
  );
endmodule
`default_nettype wire

FILE: hdl/ega_front.sv
// Front end: accept an item, classify it and push it into a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module ega_front import ega_pkg::*; #(
  parameter int FW = FitBits,
  parameter int IW = IdBits,
  parameter int QW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    cmd,
  input  wire logic [3:0]    coord_a,
  input  wire logic [3:0]    coord_b,
  input  wire logic [3:0]    coord_c,
  input  wire logic [FW-1:0] fitness,
  input  wire logic [IW-1:0] genome_id,
  input  wire logic [1:0]    dimension,
  input  wire logic [3:0]    query_value,
  input  wire logic [3:0]    range_low,
  input  wire logic [3:0]    range_high,
  output logic               q_valid,
  input  wire logic          q_pop,
  output logic [QW-1:0]      q_data
);
  localparam int BINS = BinsPerDim;

  logic [QW-1:0] entry [2];
  logic          rd_ptr, wr_ptr;
  logic [1:0]    fill;
  logic          bad;
  logic          push;

  // Classify: coordinates out of range, bad dimension, unknown command.
  always_comb begin
    bad = 1'b0;
    case (cmd)
      CMD_OFFER, CMD_READ:
        bad = (32'(coord_a) >= BINS) || (32'(coord_b) >= BINS) || (32'(coord_c) >= BINS);
      CMD_TOTAL: bad = 1'b0;
      CMD_UNIQUE, CMD_VALUE, CMD_RANGE: bad = (dimension == 2'd3);
      default: bad = 1'b1;
    endcase
  end

  assign in_ready = (fill != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (fill != 2'd0);
  assign q_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= QW'({bad, cmd, coord_a, coord_b, coord_c, fitness, genome_id,
                            dimension, query_value, range_low, range_high});
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/ega_back.sv
// Back end: cell read-modify-write in memory, value counters and count sweeps.
`timescale 1ns / 1ps
`default_nettype none
module ega_back import ega_pkg::*; #(
  parameter int FW = FitBits,
  parameter int IW = IdBits,
  parameter int QW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire logic [QW-1:0]   q_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 cell_occupied,
  output logic                 replaced,
  output logic signed [FW-1:0] elite_fitness,
  output logic [IW-1:0]        elite_id,
  output logic [CountW-1:0]    count,
  output logic                 bad_request
);
  localparam int BINS = BinsPerDim;
  localparam int BW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int CELLS = BINS * BINS * BINS;
  localparam int AW = 3 * BW;

  // Unpacked queue entry
  logic          e_bad;
  logic [2:0]    e_cmd;
  logic [3:0]    e_a, e_b, e_c, e_qv, e_lo, e_hi;
  logic [FW-1:0] e_fit;
  logic [IW-1:0] e_id;
  logic [1:0]    e_dim;
  assign {e_bad, e_cmd, e_a, e_b, e_c, e_fit, e_id, e_dim, e_qv, e_lo, e_hi} = q_data;

  back_state_t state, state_next;

  // Latched item
  cmd_t          r_cmd;
  logic [BW-1:0] r_a, r_b, r_c;
  logic [FW-1:0] r_fit;
  logic [IW-1:0] r_id;
  logic [1:0]    r_dim;
  logic [3:0]    r_lo, r_hi;

  // Cell stores
  logic             occ_mem [CELLS];
  logic [FW-1:0]    mem_fit [CELLS];
  logic [IW-1:0]    mem_id [CELLS];
  logic [FW-1:0]    rd_fit;
  logic [IW-1:0]    rd_id;
  logic             rd_occ;
  logic [AW-1:0]    addr_q, r_addr;
  logic             clr_busy;
  logic [AW-1:0]    clr_addr;
  logic             take;

  logic [CountW-1:0] vcnt [NumDims][BINS];
  logic [CountW-1:0] total;
  logic [BW:0]       sweep;
  logic [CountW-1:0] acc;
  logic              win;

  assign addr_q = {e_a[BW-1:0], e_b[BW-1:0], e_c[BW-1:0]};
  assign r_addr = {r_a, r_b, r_c};
  // Hold the queue until the occupied bits are cleared after reset
  assign take = (state == ST_IDLE) && q_valid && !clr_busy;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (take) begin
        if (e_bad || (cmd_t'(e_cmd) == CMD_TOTAL) || (cmd_t'(e_cmd) == CMD_VALUE))
          state_next = ST_EMIT;
        else if ((cmd_t'(e_cmd) == CMD_OFFER) || (cmd_t'(e_cmd) == CMD_READ))
          state_next = ST_CELL;
        else
          state_next = ST_SWEEP;
      end
      ST_CELL: state_next = ST_EMIT;
      ST_SWEEP: if (sweep == (BW + 1)'(BINS - 1)) state_next = ST_EMIT;
      ST_EMIT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = take;
    out_valid = (state == ST_EMIT);
  end

  // Signed compare of offer against incumbent
  assign win = !rd_occ || ($signed(r_fit) > $signed(rd_fit));

  always_ff @(posedge clk) begin
    if (take) begin
      r_cmd <= cmd_t'(e_cmd);
      r_a <= e_a[BW-1:0];
      r_b <= e_b[BW-1:0];
      r_c <= e_c[BW-1:0];
      r_fit <= e_fit;
      r_id <= e_id;
      r_dim <= e_dim;
      r_lo <= e_lo;
      r_hi <= e_hi;
      rd_fit <= mem_fit[addr_q];
      rd_id <= mem_id[addr_q];
      rd_occ <= occ_mem[addr_q];
    end
    if (state == ST_CELL && r_cmd == CMD_OFFER && win) begin
      mem_fit[r_addr] <= r_fit;
      mem_id[r_addr] <= r_id;
    end
    if (clr_busy) begin
      occ_mem[clr_addr] <= 1'b0;
    end else if (state == ST_CELL && r_cmd == CMD_OFFER && !rd_occ) begin
      occ_mem[r_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      clr_busy <= 1'b1;
      clr_addr <= '0;
      total <= '0;
      for (int d = 0; d < NumDims; d++)
        for (int v = 0; v < BINS; v++) vcnt[d][v] <= '0;
      cell_occupied <= 1'b0;
      replaced <= 1'b0;
      elite_fitness <= '0;
      elite_id <= '0;
      count <= '0;
      bad_request <= 1'b0;
      sweep <= '0;
      acc <= '0;
    end else begin
      state <= state_next;
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(CELLS - 1)) clr_busy <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (take) begin
          cell_occupied <= 1'b0;
          replaced <= 1'b0;
          elite_fitness <= '0;
          elite_id <= '0;
          count <= '0;
          bad_request <= e_bad;
          sweep <= '0;
          acc <= '0;
          if (!e_bad) begin
            if (cmd_t'(e_cmd) == CMD_TOTAL) count <= total;
            if (cmd_t'(e_cmd) == CMD_VALUE && 32'(e_qv) < BINS)
              count <= vcnt[e_dim][e_qv[BW-1:0]];
          end
        end
        ST_CELL: begin
          if (r_cmd == CMD_OFFER && win) begin
            replaced <= 1'b1;
            cell_occupied <= 1'b1;
            elite_fitness <= r_fit;
            elite_id <= r_id;
            if (!rd_occ) begin
              total <= total + 1'b1;
              vcnt[0][r_a] <= vcnt[0][r_a] + 1'b1;
              vcnt[1][r_b] <= vcnt[1][r_b] + 1'b1;
              vcnt[2][r_c] <= vcnt[2][r_c] + 1'b1;
            end
          end else if (rd_occ) begin
            cell_occupied <= 1'b1;
            elite_fitness <= rd_fit;
            elite_id <= rd_id;
          end
        end
        ST_SWEEP: begin
          // Walk one bin a cycle, clamping range bounds to the last bin
          logic [CountW-1:0] v;
          logic [BW:0] lo, hi;
          v = vcnt[r_dim][sweep[BW-1:0]];
          lo = (32'(r_lo) >= BINS) ? (BW + 1)'(BINS - 1) : (BW + 1)'(r_lo);
          hi = (32'(r_hi) >= BINS) ? (BW + 1)'(BINS - 1) : (BW + 1)'(r_hi);
          if (r_cmd == CMD_UNIQUE) begin
            if (v != '0) acc <= acc + 1'b1;
          end else if (sweep >= lo && sweep <= hi) begin
            acc <= acc + v;
          end
          sweep <= sweep + 1'b1;
          if (sweep == (BW + 1)'(BINS - 1)) begin
            if (r_cmd == CMD_UNIQUE) count <= acc + CountW'(v != '0);
            else count <= acc + ((sweep >= lo && sweep <= hi) ? v : '0);
          end
        end
        ST_EMIT: ;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/ega_checker.sv
// Checker: port-level assertions on the elite archive, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ega_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic cell_occupied,
  input wire logic replaced,
  input wire logic bad_request,
  input wire logic [12:0] count
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  a_repl: assert property (@(posedge clk) disable iff (rst)
    out_valid && replaced |-> cell_occupied && !bad_request)
    else $error("replaced without occupied cell");
  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_request |-> !cell_occupied && count == 13'd0)
    else $error("bad item carries data");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result right after reset");
endmodule

bind elite_grid_archive_core ega_checker u_chk (
  .clk(clk), .rst(rst),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .cell_occupied(out_ch.data.cell_occupied), .replaced(out_ch.data.replaced),
  .bad_request(out_ch.data.bad_request), .count(out_ch.data.count)
);
`default_nettype wire
